// ===== rtl/c8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types and constants for the CHIP-8 interpreter core.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int MEMORY_BYTES  = 4096;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int AddrW = $clog2(MEMORY_BYTES);
  localparam int RowW  = $clog2(SCREEN_HEIGHT);
  localparam int ColW  = $clog2(SCREEN_WIDTH);

  localparam logic [AddrW-1:0] START_RESET = 12'h200;

  localparam logic [2:0] KIND_RESET = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_EXEC  = 3'd2;
  localparam logic [2:0] KIND_TICK  = 3'd3;
  localparam logic [2:0] KIND_ROW   = 3'd4;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_OVER  = 2'd1;
  localparam logic [1:0] FAULT_UNDER = 2'd2;
  localparam logic [1:0] FAULT_OPC   = 2'd3;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OPW_CLS = 16'h00E0;
  localparam logic [15:0] OPW_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADC = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  localparam logic [7:0] MISC_GDT = 8'h07;
  localparam logic [7:0] MISC_WK  = 8'h0A;
  localparam logic [7:0] MISC_SDT = 8'h15;
  localparam logic [7:0] MISC_SST = 8'h18;
  localparam logic [7:0] MISC_ADI = 8'h1E;
  localparam logic [7:0] MISC_FNT = 8'h29;
  localparam logic [7:0] MISC_BCD = 8'h33;
  localparam logic [7:0] MISC_STR = 8'h55;
  localparam logic [7:0] MISC_LDR = 8'h65;

  typedef enum logic [4:0] {
    S_IDLE, S_FB_RD, S_FB_CAP, S_F0, S_F1, S_F2, S_VX, S_VY, S_V0, S_EXEC,
    S_WF, S_DR, S_DW, S_BCD, S_SR, S_SW, S_LR, S_LW, S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]       kind;
    logic [AddrW-1:0] address;
    logic [7:0]       data;
    logic [15:0]      keys;
    logic [7:0]       random_byte;
    logic [RowW-1:0]  row_select;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0]        pc;
    logic [SCREEN_WIDTH-1:0] display_row;
    logic                    sound_on;
    logic                    waiting_key;
    logic [1:0]              fault;
    logic                    screen_changed;
  } out_item_t;

endpackage

// ===== rtl/chip8_cpu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_cpu_core
// CHIP-8 interpreter core: memory, registers and framebuffer in sync RAMs.
// ----------------------------------------------------------------------------
// channel  direction  signals                          payload
// in       sink       in_valid_i / in_ready_o          c8_pkg::in_item_t
// out      source     out_valid_o / out_ready_i        c8_pkg::out_item_t
// cfg      sink       cfg_we_i                         cfg_wdata_i (start address)
//
// One item at a time. Load, reset, tick: accept, then result. Row read adds a
// framebuffer read and capture. Execute: accept, opcode fetch, Vx/Vy/V0 reads,
// op, result; Dxyn adds a read and write per row plus VF, Fx55/Fx65 a read and
// write per V0..Vx, Fx33 a write per digit, flag-writing ALU ops a VF write.
// Reset clears registers and screen through valid bits; no clearing pass.
// A waiting result holds the core in its final state until taken.
// ----------------------------------------------------------------------------
module chip8_cpu_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  c8_pkg::in_item_t               in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output c8_pkg::out_item_t              out_item_o,
  input  logic                           cfg_we_i,
  input  logic [c8_pkg::AddrW-1:0]       cfg_wdata_i
);

  localparam int AW   = c8_pkg::AddrW;
  localparam int SpW  = $clog2(c8_pkg::STACK_DEPTH + 1);
  localparam int SiW  = $clog2(c8_pkg::STACK_DEPTH);
  localparam int RW   = c8_pkg::RowW;
  localparam int CW   = c8_pkg::ColW;
  localparam int SW   = c8_pkg::SCREEN_WIDTH;
  localparam int SH   = c8_pkg::SCREEN_HEIGHT;

  c8_pkg::state_e state_q, state_d;
  c8_pkg::in_item_t in_q;
  c8_pkg::out_item_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  logic [AW-1:0] start_q, pc_q, pc_d, i_q, i_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [AW-1:0] stack_q [c8_pkg::STACK_DEPTH];
  logic stk_we;
  logic [7:0] dt_q, dt_d, st_q, st_d;
  logic [7:0] hi_q, hi_d, lo_q, lo_d, vx_q, vx_d, vy_q, vy_d, v0_q, v0_d;
  logic [7:0] vf_q, vf_d;
  logic [3:0] cnt_q, cnt_d;
  logic hit_q, hit_d;
  logic [15:0] v_vld_q, v_vld_d;
  logic [SH-1:0] fb_vld_q, fb_vld_d;
  logic v_rvld_q, fb_rvld_q;
  logic wait_q, wait_d, drawn_q, drawn_d;
  logic [1:0] fault_q, fault_d;
  logic [SW-1:0] row_q, row_d;

  logic          m_we, v_we, f_we;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_wdata, m_rdata;
  logic [3:0]    v_addr;
  logic [7:0]    v_wdata, v_rdata, vrd;
  logic [RW-1:0] f_addr;
  logic [SW-1:0] f_wdata, f_rdata, frd;

  logic [15:0] op;
  logic [3:0]  ox, oy, on;
  logic [7:0]  kk;
  logic [AW-1:0] nnn, nxt, skp;
  logic accept, finish;

  logic [7:0] alu_res;
  logic       alu_flag;
  logic [3:0] low_key;
  logic [1:0] bcd_h;
  logic [6:0] bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0] bcd_t, bcd_o;
  logic [7:0] sprite_rev;
  logic [2*SW-1:0] spr_dbl;
  logic [SW-1:0] spr_mask;

  c8_ram #(.Width(8), .Depth(c8_pkg::MEMORY_BYTES)) u_mem (
    .clk_i(clk_i), .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wdata), .rdata_o(m_rdata)
  );
  c8_ram #(.Width(8), .Depth(16)) u_vreg (
    .clk_i(clk_i), .we_i(v_we), .addr_i(v_addr), .wdata_i(v_wdata), .rdata_o(v_rdata)
  );
  c8_ram #(.Width(SW), .Depth(SH)) u_fb (
    .clk_i(clk_i), .we_i(f_we), .addr_i(f_addr), .wdata_i(f_wdata), .rdata_o(f_rdata)
  );

  assign vrd = v_rvld_q ? v_rdata : 8'h00;
  assign frd = fb_rvld_q ? f_rdata : '0;

  assign op  = {hi_q, lo_q};
  assign ox  = hi_q[3:0];
  assign oy  = lo_q[7:4];
  assign on  = lo_q[3:0];
  assign kk  = lo_q;
  assign nnn = op[AW-1:0];
  assign nxt = pc_q + AW'(2);
  assign skp = pc_q + AW'(4);

  assign in_ready_o  = (state_q == c8_pkg::S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign finish      = (state_q == c8_pkg::S_DONE) && (!out_vld_q || out_ready_i);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_comb begin
    alu_res  = vy_q;
    alu_flag = 1'b0;
    case (on)
      c8_pkg::ALU_MOV: alu_res = vy_q;
      c8_pkg::ALU_OR:  alu_res = vx_q | vy_q;
      c8_pkg::ALU_AND: alu_res = vx_q & vy_q;
      c8_pkg::ALU_XOR: alu_res = vx_q ^ vy_q;
      c8_pkg::ALU_ADC: {alu_flag, alu_res} = {1'b0, vx_q} + {1'b0, vy_q};
      c8_pkg::ALU_SUB: begin
        alu_res  = vx_q - vy_q;
        alu_flag = (vx_q >= vy_q);
      end
      c8_pkg::ALU_SHR: begin
        alu_res  = {1'b0, vx_q[7:1]};
        alu_flag = vx_q[0];
      end
      c8_pkg::ALU_SBN: begin
        alu_res  = vy_q - vx_q;
        alu_flag = (vy_q >= vx_q);
      end
      c8_pkg::ALU_SHL: begin
        alu_res  = {vx_q[6:0], 1'b0};
        alu_flag = vx_q[7];
      end
      default: ;
    endcase
  end

  always_comb begin
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (in_q.keys[k]) low_key = 4'(k);
    end
  end

  always_comb begin
    bcd_h    = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
    bcd_rem  = 7'(vx_q - 8'(bcd_h) * 8'd100);
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
  end

  always_comb begin
    for (int b = 0; b < 8; b++) sprite_rev[b] = m_rdata[7-b];
    spr_dbl  = {{(SW-8){1'b0}}, sprite_rev, {(SW-8){1'b0}}, sprite_rev} << vx_q[CW-1:0];
    spr_mask = spr_dbl[2*SW-1:SW];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c8_pkg::S_IDLE: begin
        if (accept) begin
          if (in_item_i.kind == c8_pkg::KIND_EXEC) state_d = c8_pkg::S_F0;
          else if (in_item_i.kind == c8_pkg::KIND_ROW) state_d = c8_pkg::S_FB_RD;
          else state_d = c8_pkg::S_DONE;
        end
      end
      c8_pkg::S_FB_RD:  state_d = c8_pkg::S_FB_CAP;
      c8_pkg::S_FB_CAP: state_d = c8_pkg::S_DONE;
      c8_pkg::S_F0:     state_d = c8_pkg::S_F1;
      c8_pkg::S_F1:     state_d = c8_pkg::S_F2;
      c8_pkg::S_F2:     state_d = c8_pkg::S_VX;
      c8_pkg::S_VX:     state_d = c8_pkg::S_VY;
      c8_pkg::S_VY:     state_d = c8_pkg::S_V0;
      c8_pkg::S_V0:     state_d = c8_pkg::S_EXEC;
      c8_pkg::S_EXEC: begin
        state_d = c8_pkg::S_DONE;
        if (op[15:12] == c8_pkg::OP_ALU) begin
          case (on)
            c8_pkg::ALU_ADC, c8_pkg::ALU_SUB, c8_pkg::ALU_SHR, c8_pkg::ALU_SBN,
            c8_pkg::ALU_SHL: state_d = c8_pkg::S_WF;
            default: ;
          endcase
        end else if (op[15:12] == c8_pkg::OP_DRW) begin
          state_d = (on == 4'd0) ? c8_pkg::S_WF : c8_pkg::S_DR;
        end else if (op[15:12] == c8_pkg::OP_MISC) begin
          if (kk == c8_pkg::MISC_BCD) state_d = c8_pkg::S_BCD;
          else if (kk == c8_pkg::MISC_STR) state_d = c8_pkg::S_SR;
          else if (kk == c8_pkg::MISC_LDR) state_d = c8_pkg::S_LR;
        end
      end
      c8_pkg::S_WF: state_d = c8_pkg::S_DONE;
      c8_pkg::S_DR: state_d = c8_pkg::S_DW;
      c8_pkg::S_DW: state_d = (cnt_q == on - 4'd1) ? c8_pkg::S_WF : c8_pkg::S_DR;
      c8_pkg::S_BCD: if (cnt_q == 4'd2) state_d = c8_pkg::S_DONE;
      c8_pkg::S_SR: state_d = c8_pkg::S_SW;
      c8_pkg::S_SW: state_d = (cnt_q == ox) ? c8_pkg::S_DONE : c8_pkg::S_SR;
      c8_pkg::S_LR: state_d = c8_pkg::S_LW;
      c8_pkg::S_LW: state_d = (cnt_q == ox) ? c8_pkg::S_DONE : c8_pkg::S_LR;
      c8_pkg::S_DONE: if (finish) state_d = c8_pkg::S_IDLE;
      default: state_d = c8_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM ports
  always_comb begin
    pc_d = pc_q; i_d = i_q; sp_d = sp_q; stk_we = 1'b0;
    dt_d = dt_q; st_d = st_q;
    hi_d = hi_q; lo_d = lo_q; vx_d = vx_q; vy_d = vy_q; v0_d = v0_q; vf_d = vf_q;
    cnt_d = cnt_q; hit_d = hit_q;
    v_vld_d = v_vld_q; fb_vld_d = fb_vld_q;
    wait_d = wait_q; drawn_d = drawn_q; fault_d = fault_q; row_d = row_q;
    out_d = out_q; out_vld_d = out_vld_q && !out_ready_i;
    m_we = 1'b0; m_addr = pc_q; m_wdata = vrd;
    v_we = 1'b0; v_addr = ox; v_wdata = alu_res;
    f_we = 1'b0; f_addr = RW'(vy_q + 8'(cnt_q)); f_wdata = frd ^ spr_mask;

    unique case (state_q)
      c8_pkg::S_IDLE: begin
        if (accept) begin
          wait_d = 1'b0; drawn_d = 1'b0; fault_d = c8_pkg::FAULT_NONE; row_d = '0;
          cnt_d = 4'd0; hit_d = 1'b0;
          case (in_item_i.kind)
            c8_pkg::KIND_RESET: begin
              pc_d = start_q; i_d = '0; sp_d = '0;
            end
            c8_pkg::KIND_LOAD: begin
              m_we = 1'b1; m_addr = in_item_i.address; m_wdata = in_item_i.data;
            end
            c8_pkg::KIND_TICK: begin
              if (dt_q != 8'd0) dt_d = dt_q - 8'd1;
              if (st_q != 8'd0) st_d = st_q - 8'd1;
            end
            default: ;
          endcase
        end
      end
      c8_pkg::S_FB_RD: f_addr = in_q.row_select;
      c8_pkg::S_FB_CAP: row_d = frd;
      c8_pkg::S_F0: m_addr = pc_q;
      c8_pkg::S_F1: begin
        hi_d = m_rdata; m_addr = pc_q + AW'(1);
      end
      c8_pkg::S_F2: begin
        lo_d = m_rdata; v_addr = ox;
      end
      c8_pkg::S_VX: begin
        vx_d = vrd; v_addr = oy;
      end
      c8_pkg::S_VY: begin
        vy_d = vrd; v_addr = 4'd0;
      end
      c8_pkg::S_V0: v0_d = vrd;
      c8_pkg::S_EXEC: begin
        pc_d = nxt;
        case (op[15:12])
          c8_pkg::OP_SYS: begin
            if (op == c8_pkg::OPW_CLS) begin
              fb_vld_d = '0; drawn_d = 1'b1;
            end else if (op == c8_pkg::OPW_RET) begin
              if (sp_q == '0) fault_d = c8_pkg::FAULT_UNDER;
              else begin
                sp_d = sp_q - SpW'(1);
                pc_d = stack_q[sp_d[SiW-1:0]];
              end
            end else fault_d = c8_pkg::FAULT_OPC;
          end
          c8_pkg::OP_JP: pc_d = nnn;
          c8_pkg::OP_CALL: begin
            if (sp_q >= SpW'(c8_pkg::STACK_DEPTH)) fault_d = c8_pkg::FAULT_OVER;
            else begin
              stk_we = 1'b1; sp_d = sp_q + SpW'(1); pc_d = nnn;
            end
          end
          c8_pkg::OP_SE:  if (vx_q == kk) pc_d = skp;
          c8_pkg::OP_SNE: if (vx_q != kk) pc_d = skp;
          c8_pkg::OP_SER: begin
            if (on != 4'd0) fault_d = c8_pkg::FAULT_OPC;
            else if (vx_q == vy_q) pc_d = skp;
          end
          c8_pkg::OP_SNER: begin
            if (on != 4'd0) fault_d = c8_pkg::FAULT_OPC;
            else if (vx_q != vy_q) pc_d = skp;
          end
          c8_pkg::OP_LD: begin
            v_we = 1'b1; v_wdata = kk;
          end
          c8_pkg::OP_ADD: begin
            v_we = 1'b1; v_wdata = vx_q + kk;
          end
          c8_pkg::OP_ALU: begin
            case (on)
              c8_pkg::ALU_MOV, c8_pkg::ALU_OR, c8_pkg::ALU_AND, c8_pkg::ALU_XOR,
              c8_pkg::ALU_ADC, c8_pkg::ALU_SUB, c8_pkg::ALU_SHR, c8_pkg::ALU_SBN,
              c8_pkg::ALU_SHL: begin
                v_we = 1'b1; vf_d = {7'd0, alu_flag};
              end
              default: fault_d = c8_pkg::FAULT_OPC;
            endcase
          end
          c8_pkg::OP_LDI: i_d = nnn;
          c8_pkg::OP_JPV: pc_d = nnn + AW'(v0_q);
          c8_pkg::OP_RND: begin
            v_we = 1'b1; v_wdata = in_q.random_byte & kk;
          end
          c8_pkg::OP_DRW: begin
            drawn_d = 1'b1; vf_d = 8'd0;
          end
          c8_pkg::OP_KEY: begin
            if (kk == c8_pkg::KEY_DOWN) begin
              if (in_q.keys[vx_q[3:0]]) pc_d = skp;
            end else if (kk == c8_pkg::KEY_UP) begin
              if (!in_q.keys[vx_q[3:0]]) pc_d = skp;
            end else fault_d = c8_pkg::FAULT_OPC;
          end
          default: begin
            case (kk)
              c8_pkg::MISC_GDT: begin
                v_we = 1'b1; v_wdata = dt_q;
              end
              c8_pkg::MISC_WK: begin
                if (in_q.keys == 16'd0) begin
                  pc_d = pc_q; wait_d = 1'b1;
                end else begin
                  v_we = 1'b1; v_wdata = {4'd0, low_key};
                end
              end
              c8_pkg::MISC_SDT: dt_d = vx_q;
              c8_pkg::MISC_SST: st_d = vx_q;
              c8_pkg::MISC_ADI: i_d = i_q + AW'(vx_q);
              c8_pkg::MISC_FNT: i_d = AW'(vx_q[3:0]) * AW'(5);
              c8_pkg::MISC_BCD, c8_pkg::MISC_STR, c8_pkg::MISC_LDR: ;
              default: fault_d = c8_pkg::FAULT_OPC;
            endcase
          end
        endcase
        if (v_we) v_vld_d[ox] = 1'b1;
      end
      c8_pkg::S_WF: begin
        v_we = 1'b1; v_addr = 4'hF; v_wdata = vf_q; v_vld_d[15] = 1'b1;
      end
      c8_pkg::S_DR: begin
        m_addr = i_q + AW'(cnt_q);
      end
      c8_pkg::S_DW: begin
        f_we = 1'b1;
        fb_vld_d[f_addr] = 1'b1;
        if ((frd & spr_mask) != '0) begin
          hit_d = 1'b1; vf_d = 8'd1;
        end
        cnt_d = cnt_q + 4'd1;
      end
      c8_pkg::S_BCD: begin
        m_we = 1'b1; m_addr = i_q + AW'(cnt_q);
        m_wdata = (cnt_q == 4'd0) ? {6'd0, bcd_h} :
                  ((cnt_q == 4'd1) ? {4'd0, bcd_t} : {4'd0, bcd_o});
        cnt_d = cnt_q + 4'd1;
      end
      c8_pkg::S_SR: v_addr = cnt_q;
      c8_pkg::S_SW: begin
        m_we = 1'b1; m_addr = i_q + AW'(cnt_q); m_wdata = vrd;
        cnt_d = cnt_q + 4'd1;
      end
      c8_pkg::S_LR: m_addr = i_q + AW'(cnt_q);
      c8_pkg::S_LW: begin
        v_we = 1'b1; v_addr = cnt_q; v_wdata = m_rdata; v_vld_d[cnt_q] = 1'b1;
        cnt_d = cnt_q + 4'd1;
      end
      c8_pkg::S_DONE: begin
        if (finish) begin
          out_vld_d = 1'b1;
          out_d.pc = pc_q;
          out_d.display_row = row_q;
          out_d.sound_on = (st_q != 8'd0);
          out_d.waiting_key = wait_q;
          out_d.fault = fault_q;
          out_d.screen_changed = drawn_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= c8_pkg::S_IDLE;
      out_vld_q <= 1'b0;
      start_q   <= c8_pkg::START_RESET;
      pc_q      <= c8_pkg::START_RESET;
      i_q       <= '0;
      sp_q      <= '0;
      dt_q      <= 8'd0;
      st_q      <= 8'd0;
      v_vld_q   <= '0;
      fb_vld_q  <= '0;
      v_rvld_q  <= 1'b0;
      fb_rvld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) start_q <= cfg_wdata_i;
      pc_q      <= pc_d;
      i_q       <= i_d;
      sp_q      <= sp_d;
      dt_q      <= dt_d;
      st_q      <= st_d;
      v_vld_q   <= v_vld_d;
      fb_vld_q  <= fb_vld_d;
      v_rvld_q  <= v_vld_q[v_addr];
      fb_rvld_q <= fb_vld_q[f_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_item_i;
    if (stk_we) stack_q[sp_q[SiW-1:0]] <= nxt;
    out_q   <= out_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    v0_q    <= v0_d;
    vf_q    <= vf_d;
    cnt_q   <= cnt_d;
    hit_q   <= hit_d;
    wait_q  <= wait_d;
    drawn_q <= drawn_d;
    fault_q <= fault_d;
    row_q   <= row_d;
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(c8_pkg::STACK_DEPTH)) else $error("stack depth out of range");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("second item taken while busy");

  a_wait_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.waiting_key |->
      (out_item_o.fault == c8_pkg::FAULT_NONE) && !out_item_o.screen_changed)
    else $error("key wait reported with other effects");

endmodule

// ===== rtl/c8_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
